// ===== src/bscs_pkg.sv =====
// ----------------------------------------------------------------------------
// bscs_pkg
// Shared types and constants of the block shape cost selector.
// ----------------------------------------------------------------------------
package bscs_pkg;

  localparam int unsigned DimW  = 16;
  localparam int unsigned SideW = 25;

  typedef struct packed {
    logic [DimW-1:0]  image_x;
    logic [DimW-1:0]  image_y;
    logic [DimW-1:0]  image_z;
    logic [DimW-1:0]  image_t;
    logic [SideW-1:0] min_side_x;
    logic [SideW-1:0] min_side_y;
    logic [SideW-1:0] min_side_z;
    logic [SideW-1:0] min_side_t;
  } req_t;

  typedef struct packed {
    logic [SideW-1:0] block_x;
    logic [SideW-1:0] block_y;
    logic [SideW-1:0] block_z;
    logic [SideW-1:0] block_t;
    logic             fell_back;
  } res_t;

  // request as handed from front to back: target already reduced to log2
  typedef struct packed {
    req_t       req;
    logic [5:0] lb;
    logic [5:0] lc;
    logic       zero;
  } job_t;

endpackage

// ===== src/bscs_if.sv =====
// ----------------------------------------------------------------------------
// bscs_req_if / bscs_res_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface bscs_req_if;
  import bscs_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bscs_res_if;
  import bscs_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/bscs_front.sv =====
// ----------------------------------------------------------------------------
// bscs_front
// Accepts requests, reduces the target to log2 values, two-entry queue.
// ----------------------------------------------------------------------------
module bscs_front
  import bscs_pkg::*;
#(
  parameter int unsigned MaxLog2 = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [SideW-1:0] target_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  req_t             in_data_i,
  output logic             job_valid_o,
  input  logic             job_ready_i,
  output job_t             job_o
);

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic [5:0] lb, lc;
  logic [32:0] tgt;
  logic        push, pop;

  always_comb begin
    tgt = {8'd0, target_i};
    if (tgt > (33'd1 << MaxLog2)) tgt = 33'd1 << MaxLog2;
    lb = '0;
    lc = '0;
    for (int i = 1; i <= 32; i++) begin
      if (i <= MaxLog2 && (33'd1 << i) <= tgt) lb = 6'(i);
      if (i <= MaxLog2 && (33'd1 << (i - 1)) < tgt) lc = 6'(i);
    end
  end

  assign in_ready_o  = cnt_q != 2'd2;
  assign job_valid_o = cnt_q != 2'd0;
  assign job_o       = mem_q[rp_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = job_valid_o && job_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= '{req: in_data_i, lb: lb, lc: lc, zero: target_i == '0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== src/bscs_back.sv =====
// ----------------------------------------------------------------------------
// bscs_back
// Enumerates shapes, scores each, keeps the best shape and the best within twice the image volume.
// ----------------------------------------------------------------------------
module bscs_back
  import bscs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic job_valid_i,
  output logic job_ready_o,
  input  job_t job_i,
  output logic res_valid_o,
  input  logic res_ready_i,
  output res_t res_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StVol  = 3'd1;
  localparam logic [2:0] StEnum = 3'd2;
  localparam logic [2:0] StCnt  = 3'd3;
  localparam logic [2:0] StProd = 3'd4;
  localparam logic [2:0] StCmp  = 3'd5;
  localparam logic [2:0] StOut  = 3'd6;

  logic [2:0]   st_q;
  job_t         job_q;
  logic [5:0]   a_q, b_q, c_q;
  logic         k_q;
  logic [127:0] vol2_q, pad_q;
  logic [16:0]  n_q [4];
  logic [31:0]  p01_q, p23_q;
  logic signed [36:0] slice_q;
  logic [50:0]  area_q;
  logic         have_q, haveq_q;
  logic signed [36:0] bs_q, qs_q;
  logic [50:0]  ba_q, qa_q;
  logic [127:0] bp_q, qp_q;
  logic [5:0]   bsh_q [4];
  logic [5:0]   qsh_q [4];
  logic         rv_q;
  res_t         res_q;

  logic [5:0]   d;
  logic [5:0]   lg [4];
  logic [15:0]  ext [4];
  logic [24:0]  mins [4];
  logic         ok, done;
  logic [16:0]  ncnt [4];
  logic         lt_b, lt_q;
  logic [5:0]   lz, ly, lx;
  logic [5:0]   ws [4];
  logic [33:0]  m01, m02, m12, m23;
  logic [31:0]  vxy, vzt;
  logic [63:0]  prod;

  assign d     = job_q.lb - a_q - b_q - c_q;
  assign lg[0] = a_q;
  assign lg[1] = b_q;
  assign lg[2] = c_q;
  assign lg[3] = d;
  assign ext[0] = job_q.req.image_x;
  assign ext[1] = job_q.req.image_y;
  assign ext[2] = job_q.req.image_z;
  assign ext[3] = job_q.req.image_t;
  assign mins[0] = job_q.req.min_side_x;
  assign mins[1] = job_q.req.min_side_y;
  assign mins[2] = job_q.req.min_side_z;
  assign mins[3] = job_q.req.min_side_t;

  always_comb begin
    ok = 1'b1;
    if (ext[2] > 16'd1) ok = (a_q == b_q) && (c_q >= 6'd2);
    else if (ext[2] == 16'd1) ok = (a_q <= b_q + 6'd2) && (b_q <= a_q + 6'd2) && c_q == '0;
    else ok = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if ((33'd1 << lg[i]) < {8'd0, mins[i]}) ok = 1'b0;
      ncnt[i] = (ext[i] == '0) ? '0 : 17'((({16'd0, ext[i]} - 32'd1) >> lg[i]) + 32'd1);
    end
  end

  assign done = (c_q == job_q.lb - a_q - b_q) && (b_q == job_q.lb - a_q) &&
                (a_q == job_q.lb);

  assign m01  = {17'd0, n_q[0]} * {17'd0, n_q[1]};
  assign m02  = {17'd0, n_q[0]} * {17'd0, n_q[2]};
  assign m12  = {17'd0, n_q[1]} * {17'd0, n_q[2]};
  assign m23  = {17'd0, n_q[2]} * {17'd0, n_q[3]};
  assign vxy  = {16'd0, job_q.req.image_x} * {16'd0, job_q.req.image_y};
  assign vzt  = {16'd0, job_q.req.image_z} * {16'd0, job_q.req.image_t};
  // shared 32x32 product for the image volume and the padded volume
  assign prod = {32'd0, p01_q} * {32'd0, p23_q};

  function automatic logic less(logic signed [36:0] s1, logic [50:0] a1, logic [127:0] p1,
                                logic signed [36:0] s2, logic [50:0] a2,
                                logic [127:0] p2);
    if (s1 != s2) return s1 < s2;
    if (a1 != a2) return a1 < a2;
    return p1 < p2;
  endfunction

  assign lt_b = !have_q || less(slice_q, area_q, pad_q, bs_q, ba_q, bp_q);
  assign lt_q = !haveq_q || less(slice_q, area_q, pad_q, qs_q, qa_q, qp_q);

  always_comb begin
    // floor(lc / 3) by reciprocal multiply
    lz = 6'(({6'd0, job_q.lc} * 12'd43) >> 7);
    ly = (job_q.lc - lz) >> 1;
    lx = job_q.lc - lz - ly;
    for (int i = 0; i < 4; i++) ws[i] = haveq_q ? qsh_q[i] : bsh_q[i];
  end

  assign job_ready_o = st_q == StIdle;
  assign res_valid_o = rv_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i) begin
    if (job_valid_i && st_q == StIdle) job_q <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      rv_q    <= 1'b0;
      have_q  <= 1'b0;
      haveq_q <= 1'b0;
      k_q <= '0;
      a_q <= '0;
      b_q <= '0;
      c_q <= '0;
    end else begin
      if (rv_q && res_ready_i) rv_q <= 1'b0;
      unique case (st_q)
        StIdle: if (job_valid_i) begin
          st_q    <= StVol;
          k_q     <= '0;
          have_q  <= 1'b0;
          haveq_q <= 1'b0;
          a_q <= '0;
          b_q <= '0;
          c_q <= '0;
        end
        StVol: begin
          if (!k_q) begin
            p01_q <= vxy;
            p23_q <= vzt;
            k_q   <= 1'b1;
          end else begin
            vol2_q <= {63'd0, prod, 1'b0};
            st_q   <= job_q.zero ? StOut : StEnum;
          end
        end
        StEnum: begin
          if (ok) begin
            for (int i = 0; i < 4; i++) n_q[i] <= ncnt[i];
            st_q <= StCnt;
          end else if (done) st_q <= StOut;
          else begin
            if (c_q != job_q.lb - a_q - b_q) c_q <= c_q + 6'd1;
            else if (b_q != job_q.lb - a_q) begin
              b_q <= b_q + 6'd1;
              c_q <= '0;
            end else begin
              a_q <= a_q + 6'd1;
              b_q <= '0;
              c_q <= '0;
            end
          end
        end
        StCnt: begin
          slice_q <= 37'sd1 + $signed({3'd0, m01}) + $signed({3'd0, m02})
                   + $signed({3'd0, m12})
                   - $signed({20'd0, n_q[0]}) - $signed({20'd0, n_q[1]})
                   - $signed({20'd0, n_q[2]});
          area_q <= (51'd1 << (a_q + b_q)) + (51'd1 << (a_q + c_q))
                  + (51'd1 << (b_q + c_q));
          p01_q <= m01[31:0];
          p23_q <= m23[31:0];
          st_q <= StProd;
        end
        StProd: begin
          // sides multiply to 2^lb, so padded volume is the block count shifted
          pad_q <= {64'd0, prod} << job_q.lb;
          st_q  <= StCmp;
        end
        StCmp: begin
          if (lt_b) begin
            have_q <= 1'b1;
            bs_q <= slice_q;
            ba_q <= area_q;
            bp_q <= pad_q;
            for (int i = 0; i < 4; i++) bsh_q[i] <= lg[i];
          end
          if (pad_q <= vol2_q && lt_q) begin
            haveq_q <= 1'b1;
            qs_q <= slice_q;
            qa_q <= area_q;
            qp_q <= pad_q;
            for (int i = 0; i < 4; i++) qsh_q[i] <= lg[i];
          end
          if (done) st_q <= StOut;
          else begin
            st_q <= StEnum;
            if (c_q != job_q.lb - a_q - b_q) c_q <= c_q + 6'd1;
            else if (b_q != job_q.lb - a_q) begin
              b_q <= b_q + 6'd1;
              c_q <= '0;
            end else begin
              a_q <= a_q + 6'd1;
              b_q <= '0;
              c_q <= '0;
            end
          end
        end
        StOut: if (!rv_q) begin
          rv_q <= 1'b1;
          st_q <= StIdle;
          if (have_q) res_q <= '{block_x: 25'd1 << ws[0], block_y: 25'd1 << ws[1],
                                 block_z: 25'd1 << ws[2], block_t: 25'd1 << ws[3],
                                 fell_back: 1'b0};
          else res_q <= '{block_x: 25'd1 << lx, block_y: 25'd1 << ly,
                          block_z: 25'd1 << lz, block_t: 25'd1, fell_back: 1'b1};
        end
        default: st_q <= StIdle;
      endcase
    end
  end

endmodule

// ===== src/block_shape_cost_selector_core.sv =====
// ----------------------------------------------------------------------------
// block_shape_cost_selector_core
// Picks a power-of-two block shape for an image by exact cost ranking.
// ----------------------------------------------------------------------------
// Usage: write target_block_voxels through cfg_we_i/cfg_wdata_i while idle.
// Send one request item (extents, minimum sides) on req; one result item
// (block sides, fell_back) comes back on res.
// The front stage takes items into a two-entry queue, so up to two requests
// wait while one is in work. The back end enumerates every shape of the
// target volume: a rejected shape ends at the check, a qualifying shape
// passes through check, count, padded-volume multiply and compare.
// One shared multiply serves the image volume and every padded volume.
// If the receiver stalls, the result register holds and further items
// queue in the front until it is full.
// Reset clears the queue and state; the target returns to 1048576.
// ----------------------------------------------------------------------------
module block_shape_cost_selector_core
  import bscs_pkg::*;
#(
  parameter int unsigned MaxBlockLog2 = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [SideW-1:0] cfg_wdata_i,
  bscs_req_if.sink         req,
  bscs_res_if.source       res
);

  logic [SideW-1:0] target_q;
  logic             job_valid, job_ready;
  job_t             job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) target_q <= SideW'(1048576);
    else if (cfg_we_i) target_q <= cfg_wdata_i;
  end

  bscs_front #(.MaxLog2(MaxBlockLog2)) u_front (
    .clk_i, .rst_ni, .target_i(target_q),
    .in_valid_i(req.valid), .in_ready_o(req.ready), .in_data_i(req.data),
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  bscs_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job),
    .res_valid_o(res.valid), .res_ready_i(res.ready), .res_o(res.data)
  );

endmodule
